FILE: rtl/rtri_pkg.sv
package rtri_pkg;

   localparam int MAX_COLUMNS = 16;
   localparam int MAX_ROWS    = 16;
   localparam int MAX_LEN     = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;

   // field widths fixed by the interface
   localparam int STEP_W  = 2;
   localparam int SLOT_W  = 9;
   localparam int DELTA_W = 6;
   localparam int CFG_W   = 5;

   // slot counts, ring indices and ring lengths
   localparam int LEN_W   = $clog2(MAX_LEN + 1);
   localparam int HALF_W  = $clog2(2 * MAX_LEN);
   localparam int TWICE_W = LEN_W + 1;

   localparam int RESET_COLUMNS = (MAX_COLUMNS < 8) ? MAX_COLUMNS : 8;
   localparam int RESET_ROWS    = (MAX_ROWS < 8) ? MAX_ROWS : 8;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] REG_SLOT_COLUMNS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_SLOT_ROWS    = 1'b1;

   localparam int STEP_CNT_W = 4;
   typedef logic [STEP_CNT_W-1:0] step_type;

   typedef enum logic [2:0] {
      OP_ACCEPT,
      OP_MOVE_COL,
      OP_EMIT_COL,
      OP_MOVE_ROW,
      OP_EMIT_ROW
   } op_type;

   typedef enum logic {
      AXIS_X,
      AXIS_Y
   } axis_type;

   typedef struct packed {
      op_type   op;
      axis_type axis;
      logic     skip;      // jump to skip_to when the axis has no movement
      step_type skip_to;
      step_type next;      // taken once the step is complete
   } ctrl_word_type;

   typedef struct packed {
      logic done;
      logic dir_zero;
   } status_type;

endpackage

FILE: rtl/rtri_ifs.sv
interface rtri_req_if import rtri_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [STEP_W-1:0] step_x;
   logic signed [STEP_W-1:0] step_y;

   modport source(output valid, step_x, step_y, input ready);
   modport sink(input valid, step_x, step_y, output ready);
endinterface

interface rtri_rsp_if import rtri_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic        [SLOT_W-1:0]  slot_index;
   logic signed [DELTA_W-1:0] delta_map_x;
   logic signed [DELTA_W-1:0] delta_map_y;
   logic                      last_of_step;

   modport source(output valid, slot_index, delta_map_x, delta_map_y, last_of_step,
                  input ready);
   modport sink(input valid, slot_index, delta_map_x, delta_map_y, last_of_step,
                output ready);
endinterface

FILE: rtl/rtri_sequencer.sv
module rtri_sequencer import rtri_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  status_type    status,
   output ctrl_word_type ctrl
);

   localparam step_type ST_ACCEPT     = 4'd0;
   localparam step_type ST_MOVE_COL_X = 4'd1;
   localparam step_type ST_EMIT_COL_X = 4'd2;
   localparam step_type ST_MOVE_ROW_X = 4'd3;
   localparam step_type ST_EMIT_ROW_X = 4'd4;
   localparam step_type ST_MOVE_COL_Y = 4'd5;
   localparam step_type ST_EMIT_COL_Y = 4'd6;
   localparam step_type ST_MOVE_ROW_Y = 4'd7;
   localparam step_type ST_EMIT_ROW_Y = 4'd8;

   function automatic ctrl_word_type program_rom(step_type s);
      ctrl_word_type w;
      w = '{op: OP_ACCEPT, axis: AXIS_X, skip: 1'b0, skip_to: ST_ACCEPT, next: ST_ACCEPT};
      case (s)
         ST_ACCEPT:     w = '{OP_ACCEPT,   AXIS_X, 1'b0, ST_ACCEPT,     ST_MOVE_COL_X};
         ST_MOVE_COL_X: w = '{OP_MOVE_COL, AXIS_X, 1'b1, ST_MOVE_COL_Y, ST_EMIT_COL_X};
         ST_EMIT_COL_X: w = '{OP_EMIT_COL, AXIS_X, 1'b0, ST_ACCEPT,     ST_MOVE_ROW_X};
         ST_MOVE_ROW_X: w = '{OP_MOVE_ROW, AXIS_X, 1'b0, ST_ACCEPT,     ST_EMIT_ROW_X};
         ST_EMIT_ROW_X: w = '{OP_EMIT_ROW, AXIS_X, 1'b0, ST_ACCEPT,     ST_MOVE_COL_Y};
         ST_MOVE_COL_Y: w = '{OP_MOVE_COL, AXIS_Y, 1'b1, ST_ACCEPT,     ST_EMIT_COL_Y};
         ST_EMIT_COL_Y: w = '{OP_EMIT_COL, AXIS_Y, 1'b0, ST_ACCEPT,     ST_MOVE_ROW_Y};
         ST_MOVE_ROW_Y: w = '{OP_MOVE_ROW, AXIS_Y, 1'b0, ST_ACCEPT,     ST_EMIT_ROW_Y};
         ST_EMIT_ROW_Y: w = '{OP_EMIT_ROW, AXIS_Y, 1'b0, ST_ACCEPT,     ST_ACCEPT};
         default:       w = '{OP_ACCEPT,   AXIS_X, 1'b0, ST_ACCEPT,     ST_ACCEPT};
      endcase
      return w;
   endfunction

   step_type step_ff;
   step_type step_in;

   assign ctrl = program_rom(step_ff);

   always_comb begin
      step_in = step_ff;
      if (ctrl.skip && status.dir_zero) begin
         step_in = ctrl.skip_to;
      end else if (status.done) begin
         step_in = ctrl.next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_ACCEPT;
      end else begin
         step_ff <= step_in;
      end
   end

   a_step_in_program: assert property (@(posedge clock) disable iff (reset)
      step_ff <= ST_EMIT_ROW_Y)
      else $error("step counter outside program");

   a_accept_starts_x: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_ACCEPT && status.done) |=> step_ff == ST_MOVE_COL_X)
      else $error("accepted beat did not start the x part");

   a_last_row_returns: assert property (@(posedge clock) disable iff (reset)
      (step_ff == ST_EMIT_ROW_Y && status.done) |=> ctrl.op == OP_ACCEPT)
      else $error("sequencer did not return to accept");

endmodule

FILE: rtl/rtri_datapath.sv
module rtri_datapath import rtri_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_word_type          ctrl,
   output status_type             status,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_wdata,
   rtri_req_if.sink               req_bus,
   rtri_rsp_if.source             rsp_bus
);

   localparam int SUM_W = HALF_W + LEN_W + 1;

   function automatic logic [LEN_W-1:0] sat_len(logic [CFG_W-1:0] v, int lim);
      if (v == '0) return LEN_W'(1);
      if (int'(v) > lim) return LEN_W'(lim);
      return LEN_W'(v);
   endfunction

   logic [LEN_W-1:0]          cols_ff, cols_in, rows_ff, rows_in;
   logic [HALF_W-1:0]         ring_col_ff, ring_col_in, ring_row_ff, ring_row_in;
   logic [STEP_W-1:0]         dx_ff, dx_in, dy_ff, dy_in;
   logic [HALF_W-1:0]         moved_ff, moved_in, walk_ff, walk_in;
   logic [LEN_W-1:0]          count_ff, count_in;
   logic signed [DELTA_W-1:0] dlt_x_ff, dlt_x_in, dlt_y_ff, dlt_y_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]         slot_ff, slot_in;
   logic signed [DELTA_W-1:0] dmx_ff, dmx_in, dmy_ff, dmy_in;
   logic                      last_ff, last_in;

   logic [TWICE_W-1:0]        tc, tr, rc_ext, rr_ext, nr, ws, w2, wrap_len;
   logic [STEP_W-1:0]         dir;
   logic                      dir_zero, col_adv, row_adv, norm_busy, out_free;
   logic                      emitting, final_beat, req_fire;
   logic [LEN_W-1:0]          limit;
   logic [HALF_W-1:0]         mv, mul_a, add_b;
   logic [SUM_W-1:0]          slot_sum;
   logic signed [DELTA_W-1:0] cols_d, rows_d;

   assign tc     = {cols_ff, 1'b0};
   assign tr     = {rows_ff, 1'b0};
   assign rc_ext = TWICE_W'(ring_col_ff);
   assign rr_ext = TWICE_W'(ring_row_ff);
   assign cols_d = DELTA_W'(cols_ff);
   assign rows_d = DELTA_W'(rows_ff);

   assign dir      = (ctrl.axis == AXIS_X) ? dx_ff : dy_ff;
   assign dir_zero = (dir == '0);
   // x scrolls the column ring along its sign, y against it
   assign col_adv  = (ctrl.axis == AXIS_X) ? !dx_ff[1] : dy_ff[1];
   assign row_adv  = !dir[1];

   // ring left out of range by a length write: one subtract a cycle while in the accept step
   assign norm_busy = (rc_ext >= tc) || (rr_ext >= tr);
   assign req_bus.ready = (ctrl.op == OP_ACCEPT) && !norm_busy;
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign out_free   = !rsp_valid_ff || rsp_bus.ready;
   assign emitting   = (ctrl.op == OP_EMIT_COL || ctrl.op == OP_EMIT_ROW) && out_free;
   assign limit      = (ctrl.op == OP_EMIT_COL) ? rows_ff : cols_ff;
   assign final_beat = (LEN_W'(count_ff + 1'b1) == limit);
   assign wrap_len   = (ctrl.op == OP_EMIT_COL) ? tr : tc;
   assign w2         = TWICE_W'(walk_ff) + TWICE_W'(2);

   // column phase: walker is the half-row; row phase: walker is the half-column
   assign mul_a    = (ctrl.op == OP_EMIT_COL) ? walk_ff : moved_ff;
   assign add_b    = (ctrl.op == OP_EMIT_COL) ? moved_ff : walk_ff;
   assign slot_sum = SUM_W'(mul_a) * SUM_W'(cols_ff) + SUM_W'(add_b >> 1);

   always_comb begin
      cols_in      = cols_ff;
      rows_in      = rows_ff;
      ring_col_in  = ring_col_ff;
      ring_row_in  = ring_row_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      moved_in     = moved_ff;
      walk_in      = walk_ff;
      count_in     = count_ff;
      dlt_x_in     = dlt_x_ff;
      dlt_y_in     = dlt_y_ff;
      slot_in      = slot_ff;
      dmx_in       = dmx_ff;
      dmy_in       = dmy_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      nr           = '0;
      ws           = '0;
      mv           = '0;
      status       = '{done: 1'b0, dir_zero: dir_zero};

      if (csr_we) begin
         case (csr_index)
            REG_SLOT_COLUMNS: cols_in = sat_len(csr_wdata, MAX_COLUMNS);
            REG_SLOT_ROWS:    rows_in = sat_len(csr_wdata, MAX_ROWS);
            default: ;
         endcase
      end

      case (ctrl.op)
         OP_ACCEPT: begin
            if (rc_ext >= tc) ring_col_in = HALF_W'(rc_ext - tc);
            if (rr_ext >= tr) ring_row_in = HALF_W'(rr_ext - tr);
            if (req_fire) begin
               dx_in = req_bus.step_x;
               dy_in = req_bus.step_y;
            end
            status.done = req_fire;
         end
         OP_MOVE_COL: begin
            if (col_adv) begin
               nr = (rc_ext + 1'b1 == tc) ? '0 : rc_ext + 1'b1;
               mv = ring_col_ff;
            end else begin
               nr = (rc_ext == '0) ? tc - 1'b1 : rc_ext - 1'b1;
               mv = HALF_W'(nr);
            end
            ws = rr_ext + TWICE_W'(ring_row_ff[0] ^ mv[0]);
            if (ws >= tr) ws = ws - tr;
            if (!dir_zero) begin
               ring_col_in = HALF_W'(nr);
               moved_in    = mv;
               walk_in     = HALF_W'(ws);
               count_in    = '0;
               dlt_x_in    = col_adv ? cols_d : -cols_d;
               dlt_y_in    = col_adv ? -cols_d : cols_d;
            end
            status.done = 1'b1;
         end
         OP_MOVE_ROW: begin
            if (row_adv) begin
               nr = (rr_ext + 1'b1 == tr) ? '0 : rr_ext + 1'b1;
               mv = ring_row_ff;
            end else begin
               nr = (rr_ext == '0) ? tr - 1'b1 : rr_ext - 1'b1;
               mv = HALF_W'(nr);
            end
            ws = rc_ext + TWICE_W'(ring_col_ff[0] ^ mv[0]);
            if (ws >= tc) ws = ws - tc;
            ring_row_in = HALF_W'(nr);
            moved_in    = mv;
            walk_in     = HALF_W'(ws);
            count_in    = '0;
            dlt_x_in    = row_adv ? rows_d : -rows_d;
            dlt_y_in    = row_adv ? rows_d : -rows_d;
            status.done = 1'b1;
         end
         OP_EMIT_COL, OP_EMIT_ROW: begin
            if (emitting) begin
               rsp_valid_in = 1'b1;
               slot_in      = SLOT_W'(slot_sum);
               dmx_in       = dlt_x_ff;
               dmy_in       = dlt_y_ff;
               // last beat of the item: row phase of y, or of x when y is still
               last_in      = final_beat && (ctrl.op == OP_EMIT_ROW)
                              && (ctrl.axis == AXIS_Y || dy_ff == '0);
               count_in     = LEN_W'(count_ff + 1'b1);
               walk_in      = HALF_W'((w2 >= wrap_len) ? w2 - wrap_len : w2);
               status.done  = final_beat;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff      <= LEN_W'(RESET_COLUMNS);
         rows_ff      <= LEN_W'(RESET_ROWS);
         ring_col_ff  <= '0;
         ring_row_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         ring_col_ff  <= ring_col_in;
         ring_row_ff  <= ring_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      moved_ff <= moved_in;
      walk_ff  <= walk_in;
      count_ff <= count_in;
      dlt_x_ff <= dlt_x_in;
      dlt_y_ff <= dlt_y_in;
      slot_ff  <= slot_in;
      dmx_ff   <= dmx_in;
      dmy_ff   <= dmy_in;
      last_ff  <= last_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.slot_index   = slot_ff;
   assign rsp_bus.delta_map_x  = dmx_ff;
   assign rsp_bus.delta_map_y  = dmy_ff;
   assign rsp_bus.last_of_step = last_ff;

   a_new_beat_from_emit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff))
         |-> ($past(ctrl.op) == OP_EMIT_COL || $past(ctrl.op) == OP_EMIT_ROW))
      else $error("result beat raised outside an emit step");

   a_accept_normalised: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (rc_ext < tc && rr_ext < tr))
      else $error("beat taken with a ring index out of range");

   a_no_emit_while_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |-> !emitting)
      else $error("emit while output beat still pending");

endmodule

FILE: rtl/ring_tile_recycle_indexer_unit.sv
// Once an input beat is taken the x part runs first, skipped when x does not
// move. One axis gives rows + cols beats, column phase then row phase; both
// axes run x then y, and no movement gives no beats. One result beat per cycle
// while emitting, unless the output is stalled. Items are taken one at a time;
// a length write may hold off the next item while the ring indices are brought
// back in range.
// Reset (synchronous, active high): 8 columns, 8 rows, both ring indices zero.
module ring_tile_recycle_indexer_unit import rtri_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   rtri_req_if.sink               req_bus,
   rtri_rsp_if.source             rsp_bus,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_wdata
);

   ctrl_word_type ctrl;
   status_type    status;

   rtri_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   rtri_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .status    (status),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

endmodule

FILE: dv/ring_tile_recycle_indexer_unit_test.sv
`timescale 1ns / 100ps

module ring_tile_recycle_indexer_unit_test;
   import rtri_pkg::*;

   localparam logic [STEP_W-1:0] STEP_NONE     = 2'b00;
   localparam logic [STEP_W-1:0] STEP_FWD      = 2'b01;
   localparam logic [STEP_W-1:0] STEP_BACK_ALT = 2'b10;
   localparam logic [STEP_W-1:0] STEP_BACK     = 2'b11;

   localparam int SETTLE_CYCLES  = 8;
   localparam int TAIL_CYCLES    = 10;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_STEPS    = 16;

   typedef struct {
      logic        [SLOT_W-1:0]  slot;
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
      logic                      step_end;
   } slot_move_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CFG_W-1:0]       csr_wdata;

   rtri_req_if req_bus ();
   rtri_rsp_if rsp_bus ();

   ring_tile_recycle_indexer_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // grid state as the block should hold it
   int grid_cols;
   int grid_rows;
   int col_ring;
   int row_ring;

   slot_move_type pending_moves[$];

   bit steady_run;
   int fail_count;
   int steps_sent;
   int moves_checked;
   int csr_writes;
   int quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // grid recycling predictor
   // ---------------------------------------------------------------
   function automatic int step_dir(logic [STEP_W-1:0] code);
      case (code)
         STEP_NONE: return 0;
         STEP_FWD:  return 1;
         default:   return -1;  // both negative patterns count as minus one
      endcase
   endfunction

   function automatic void queue_move(int slot, int dx, int dy);
      slot_move_type m;
      m.slot     = slot[SLOT_W-1:0];
      m.dx       = dx[DELTA_W-1:0];
      m.dy       = dy[DELTA_W-1:0];
      m.step_end = 1'b0;
      pending_moves.push_back(m);
   endfunction

   function automatic void recycle_unit(bit col_adv, bit row_adv, int cdx, int cdy, int rd);
      int tc;
      int tr;
      int mc;
      int mr;
      int hr;
      int hc;
      tc = 2 * grid_cols;
      tr = 2 * grid_rows;
      if (col_adv) begin
         mc = col_ring;
         col_ring = (col_ring + 1) % tc;
      end else begin
         col_ring = (col_ring + tc - 1) % tc;
         mc = col_ring;
      end
      for (int k = 0; k < grid_rows; k++) begin
         hr = (2 * k + row_ring + ((row_ring & 1) ^ (mc & 1))) % tr;
         queue_move(hr * grid_cols + mc / 2, cdx, cdy);
      end
      if (row_adv) begin
         mr = row_ring;
         row_ring = (row_ring + 1) % tr;
      end else begin
         row_ring = (row_ring + tr - 1) % tr;
         mr = row_ring;
      end
      for (int k = 0; k < grid_cols; k++) begin
         hc = (2 * k + col_ring + ((col_ring & 1) ^ (mr & 1))) % tc;
         queue_move(mr * grid_cols + hc / 2, rd, rd);
      end
   endfunction

   function automatic void recycle_step(logic [STEP_W-1:0] sx, logic [STEP_W-1:0] sy);
      int dx;
      int dy;
      int before_cnt;
      slot_move_type m;
      dx = step_dir(sx);
      dy = step_dir(sy);
      before_cnt = pending_moves.size();
      if (dx != 0)
         recycle_unit(dx > 0, dx > 0, dx * grid_cols, -dx * grid_cols, dx * grid_rows);
      if (dy != 0)
         recycle_unit(dy < 0, dy > 0, -dy * grid_cols, dy * grid_cols, dy * grid_rows);
      if (pending_moves.size() > before_cnt) begin
         m = pending_moves.pop_back();
         m.step_end = 1'b1;
         pending_moves.push_back(m);
      end
   endfunction

   function automatic void apply_register(logic [CSR_INDEX_W-1:0] idx, logic [CFG_W-1:0] val);
      int v;
      v = (val == 0) ? 1 : int'(val);
      if (idx == REG_SLOT_COLUMNS) begin
         grid_cols = (v > MAX_COLUMNS) ? MAX_COLUMNS : v;
         col_ring  = col_ring % (2 * grid_cols);
      end else if (idx == REG_SLOT_ROWS) begin
         grid_rows = (v > MAX_ROWS) ? MAX_ROWS : v;
         row_ring  = row_ring % (2 * grid_rows);
      end
   endfunction

   // ---------------------------------------------------------------
   // result side: random back-pressure and checking
   // ---------------------------------------------------------------
   initial begin
      int hold;
      hold = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (steady_run) begin
            rsp_bus.ready <= 1'b1;
         end else if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            hold--;
         end else if ($urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            hold = $urandom_range(0, 3);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      slot_move_type m;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_moves.size() == 0) begin
            $error("unexpected beat: slot_index %0d", rsp_bus.slot_index);
            fail_count++;
         end else begin
            m = pending_moves.pop_front();
            moves_checked++;
            if (rsp_bus.slot_index !== m.slot) begin
               $error("slot_index: expected %0d, got %0d", m.slot, rsp_bus.slot_index);
               fail_count++;
            end
            if (rsp_bus.delta_map_x !== m.dx) begin
               $error("delta_map_x: expected %0d, got %0d", m.dx, rsp_bus.delta_map_x);
               fail_count++;
            end
            if (rsp_bus.delta_map_y !== m.dy) begin
               $error("delta_map_y: expected %0d, got %0d", m.dy, rsp_bus.delta_map_y);
               fail_count++;
            end
            if (rsp_bus.last_of_step !== m.step_end) begin
               $error("last_of_step: expected %0d, got %0d", m.step_end,
                      rsp_bus.last_of_step);
               fail_count++;
            end
         end
      end
   end

   // no beat moving on either side for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d updates outstanding",
                  quiet_cycles, pending_moves.size());
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------
   task automatic send_step(input logic [STEP_W-1:0] sx, input logic [STEP_W-1:0] sy);
      if (!steady_run && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.step_x <= sx;
      req_bus.step_y <= sy;
      do @(posedge clock); while (!req_bus.ready);
      recycle_step(sx, sy);
      steps_sent++;
   endtask

   // block drained and quiet; steps with no movement leave nothing to wait on
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pending_moves.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      apply_register(idx, val);
      csr_writes++;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------
   task automatic test_unit_steps();
      send_step(STEP_FWD, STEP_NONE);
      send_step(STEP_BACK, STEP_NONE);
      send_step(STEP_NONE, STEP_FWD);
      send_step(STEP_NONE, STEP_BACK);
      send_step(STEP_NONE, STEP_NONE);
      send_step(STEP_FWD, STEP_FWD);
      send_step(STEP_BACK_ALT, STEP_BACK_ALT);
      send_step(STEP_FWD, STEP_BACK_ALT);
      send_step(STEP_BACK, STEP_FWD);
   endtask

   task automatic test_register_saturation();
      settle();
      write_reg(REG_SLOT_COLUMNS, 5'd0);
      write_reg(REG_SLOT_ROWS, 5'd31);
      send_step(STEP_FWD, STEP_BACK);
      send_step(STEP_BACK, STEP_FWD);
      settle();
      write_reg(REG_SLOT_COLUMNS, 5'd17);
      write_reg(REG_SLOT_ROWS, 5'd0);
      send_step(STEP_BACK_ALT, STEP_FWD);
      send_step(STEP_NONE, STEP_BACK);
      settle();
      write_reg(REG_SLOT_COLUMNS, 5'd16);
      write_reg(REG_SLOT_ROWS, 5'd16);
      send_step(STEP_FWD, STEP_FWD);
      send_step(STEP_BACK, STEP_BACK);
      settle();
      write_reg(REG_SLOT_COLUMNS, 5'd1);
      write_reg(REG_SLOT_ROWS, 5'd1);
      send_step(STEP_FWD, STEP_FWD);
      send_step(STEP_BACK_ALT, STEP_NONE);
   endtask

   // push both rings to the top of a full grid, then shrink under them
   task automatic test_ring_shrink();
      settle();
      write_reg(REG_SLOT_COLUMNS, 5'd16);
      write_reg(REG_SLOT_ROWS, 5'd16);
      send_step(STEP_BACK, STEP_NONE);
      settle();
      write_reg(REG_SLOT_COLUMNS, 5'd3);
      write_reg(REG_SLOT_ROWS, 5'd5);
      send_step(STEP_FWD, STEP_NONE);
      send_step(STEP_NONE, STEP_BACK_ALT);
   endtask

   task automatic test_random_scroll();
      int moving;
      logic [STEP_W-1:0] sx;
      logic [STEP_W-1:0] sy;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         if (p == RANDOM_PHASES - 1) steady_run = 1'b1;
         // mostly small grids, now and then anything the register holds
         if ($urandom_range(0, 2) == 0)
            write_reg(REG_SLOT_COLUMNS, CFG_W'($urandom_range(0, 31)));
         else
            write_reg(REG_SLOT_COLUMNS, CFG_W'($urandom_range(1, 6)));
         if ($urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 2) == 0)
               write_reg(REG_SLOT_ROWS, CFG_W'($urandom_range(0, 31)));
            else
               write_reg(REG_SLOT_ROWS, CFG_W'($urandom_range(1, 6)));
         end
         moving = 0;
         while (moving < PHASE_STEPS) begin
            sx = STEP_W'($urandom);
            sy = STEP_W'($urandom);
            send_step(sx, sy);
            if (sx != STEP_NONE || sy != STEP_NONE) moving++;
         end
      end
   endtask

   // ---------------------------------------------------------------
   initial begin
      reset          = 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.step_x <= STEP_NONE;
      req_bus.step_y <= STEP_NONE;
      csr_we         <= 1'b0;
      csr_index      <= REG_SLOT_COLUMNS;
      csr_wdata      <= '0;
      steady_run     = 1'b0;
      fail_count     = 0;
      steps_sent     = 0;
      moves_checked  = 0;
      csr_writes     = 0;
      quiet_cycles   = 0;
      grid_cols      = 8;
      grid_rows      = 8;
      col_ring       = 0;
      row_ring       = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_unit_steps();
      test_register_saturation();
      test_ring_shrink();
      test_random_scroll();

      req_bus.valid <= 1'b0;
      while (pending_moves.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d scroll steps and %0d register writes, %0d slot updates checked",
               steps_sent, csr_writes, moves_checked);
      $display("grids from 1x1 to 16x16, saturating writes, ring shrink and both -1 codes");
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
